### src/knapsack_with_attachments_defines.svh
// Assertion macros shared by the knapsack block.
`ifndef KNAPSACK_WITH_ATTACHMENTS_DEFINES_SVH
`define KNAPSACK_WITH_ATTACHMENTS_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define KWA_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low
`define KWA_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/kwa_pkg.sv
// Shared types, widths and controller/datapath interface of the knapsack block.
`timescale 1ns / 1ps

package kwa_pkg;

    // Field widths
    localparam int COST_W       = 15;
    localparam int PRIO_W       = 3;
    localparam int PARENT_W     = 7;
    localparam int BUDGET_W     = 15;
    localparam int VALUE_W      = 18;
    localparam int COMBO_COST_W = 17;
    localparam int COMBO_VAL_W  = 20;
    localparam int CAND_W       = 21;
    localparam int ACNT_W       = 2;
    localparam int IN_TDATA_W   = 32;
    localparam int OUT_TDATA_W  = 24;

    // Default sizing
    localparam int DEF_MAX_ITEMS   = 64;
    localparam int DEF_TABLE_DEPTH = 32768;

    // Controller states
    typedef enum logic [4:0] {
        S_ATT_CLR,
        S_LOAD,
        S_DRAIN,
        S_ZERO,
        S_M_RD,
        S_M_CAP,
        S_A_CAP,
        S_B_CAP,
        S_SUM,
        S_DP0,
        S_DP1,
        S_DP2,
        S_DP3,
        S_DP4,
        S_DPW,
        S_NEXT,
        S_RES_RD,
        S_RES
    } state_t;

    // Item memory read source
    typedef enum logic [1:0] {
        IRD_NONE,
        IRD_MAIN,
        IRD_A,
        IRD_B
    } item_rd_t;

    // Table read kind: own entry, one of four choices, or the clamped capacity
    typedef enum logic [2:0] {
        TRD_NONE,
        TRD_SELF,
        TRD_C0,
        TRD_C1,
        TRD_C2,
        TRD_C3,
        TRD_CAP
    } tbl_rd_t;

    // Stored item: main flag, priority, cost
    typedef struct packed {
        logic              is_main;
        logic [PRIO_W-1:0] prio;
        logic [COST_W-1:0] cost;
    } item_word_t;

    // Controller to datapath
    typedef struct packed {
        logic     in_ready;
        logic     att_clr;
        logic     sweep_clear;
        logic     cnt_clear;
        logic     i_first;
        logic     i_next;
        logic     v_load_cap;
        logic     v_dec;
        item_rd_t item_rd;
        logic     att_rd_main;
        logic     cap_main;
        logic     cap_a;
        logic     cap_b;
        logic     cap_combo;
        tbl_rd_t  tbl_rd;
        logic     tbl_wr_zero;
        logic     tbl_wr_acc;
        logic     out_load;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic last_accepted;
        logic sweep_last;
        logic no_items;
        logic main_last;
        logic is_main;
        logic mc_over_cap;
        logic v_zero;
        logic v_at_mc;
        logic out_busy;
    } status_t;

endpackage

### src/knapsack_with_attachments.sv
// Top level of the main-plus-attachments knapsack solver.
//
//  channel   direction  transaction contents
//  s_axis    in         one item: tdata cost/priority/parent, tlast ends the problem
//  m_axis    out        one best value after each problem
//  cfg       in         budget write, taken on every edge with cfg_wr_en high
//
// Items load at one per cycle. After the last item the block stops accepting,
// zeroes the table, skips each non-main item and each main item with cost above
// cap, and for every other main item relaxes each table entry from cap down to its
// cost (one table port, six accesses per entry), then reads the result,
// where cap = min(budget, TABLE_DEPTH-1).
// After reset and after each result, a clearing pass runs over every entry of the
// attachment memory before items are accepted again.
// A waiting result holds in m_axis; a following problem stalls only at its result.
`timescale 1ns / 1ps

`include "knapsack_with_attachments_defines.svh"

module knapsack_with_attachments import kwa_pkg::*;
#(
    parameter int MAX_ITEMS   = DEF_MAX_ITEMS,
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // budget
    input  logic                   cfg_wr_en,
    input  logic [BUDGET_W-1:0]    cfg_wr_data,
    // item stream
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // item_cost, item_priority, parent_index
    input  logic                   s_axis_tlast,   // last_item
    // result stream
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata    // best_value
);

    cmd_t    cmd;
    status_t status;
    logic    item_last_txn;

    // Controller
    kwa_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd)
    );

    // Datapath
    kwa_dp #(
        .MAX_ITEMS   (MAX_ITEMS),
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    assign s_axis_tready = cmd.in_ready;
    assign item_last_txn = s_axis_tvalid && s_axis_tready && s_axis_tlast;

    // Checks
    `KWA_ASSERT_NXT(a_stop_after_last, item_last_txn, !s_axis_tready, "item after last")
    `KWA_ASSERT_IMP(a_no_overwrite, cmd.out_load, !m_axis_tvalid, "load over a waiting result")
    `KWA_ASSERT_IMP(a_valid_src, $rose(m_axis_tvalid), $past(cmd.out_load), "valid without load")
    `KWA_ASSERT_IMP(a_no_load_in_clear, cmd.att_clr, !s_axis_tready, "ready during clear")

endmodule

### src/kwa_ctrl.sv
// Sequencing state machine for load, table sweep, knapsack walk and result.
`timescale 1ns / 1ps

module kwa_ctrl import kwa_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_ATT_CLR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_ATT_CLR:
            begin
                if (status.sweep_last)
                begin
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                if (status.last_accepted)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_ZERO;
            end
            S_ZERO:
            begin
                if (status.v_zero)
                begin
                    state_next = status.no_items ? S_RES_RD : S_M_RD;
                end
            end
            S_M_RD:
            begin
                state_next = S_M_CAP;
            end
            S_M_CAP:
            begin
                state_next = status.is_main ? S_A_CAP : S_NEXT;
            end
            S_A_CAP:
            begin
                state_next = S_B_CAP;
            end
            S_B_CAP:
            begin
                state_next = S_SUM;
            end
            S_SUM:
            begin
                state_next = status.mc_over_cap ? S_NEXT : S_DP0;
            end
            S_DP0:
            begin
                state_next = S_DP1;
            end
            S_DP1:
            begin
                state_next = S_DP2;
            end
            S_DP2:
            begin
                state_next = S_DP3;
            end
            S_DP3:
            begin
                state_next = S_DP4;
            end
            S_DP4:
            begin
                state_next = S_DPW;
            end
            S_DPW:
            begin
                state_next = status.v_at_mc ? S_NEXT : S_DP0;
            end
            S_NEXT:
            begin
                state_next = status.main_last ? S_RES_RD : S_M_RD;
            end
            S_RES_RD:
            begin
                state_next = S_RES;
            end
            S_RES:
            begin
                if (!status.out_busy)
                begin
                    state_next = S_ATT_CLR;
                end
            end
            default:
            begin
                state_next = S_ATT_CLR;
            end
        endcase
    end

    // Command outputs
    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            S_ATT_CLR:
            begin
                cmd.att_clr = 1'b1;
            end
            S_LOAD:
            begin
                cmd.in_ready = 1'b1;
            end
            S_DRAIN:
            begin
                cmd.v_load_cap = 1'b1;
            end
            S_ZERO:
            begin
                cmd.tbl_wr_zero = 1'b1;
                cmd.v_dec       = !status.v_zero;
                cmd.i_first     = status.v_zero;
            end
            S_M_RD:
            begin
                cmd.item_rd     = IRD_MAIN;
                cmd.att_rd_main = 1'b1;
            end
            S_M_CAP:
            begin
                cmd.cap_main = 1'b1;
                cmd.item_rd  = IRD_A;
            end
            S_A_CAP:
            begin
                cmd.cap_a   = 1'b1;
                cmd.item_rd = IRD_B;
            end
            S_B_CAP:
            begin
                cmd.cap_b = 1'b1;
            end
            S_SUM:
            begin
                cmd.cap_combo  = 1'b1;
                cmd.v_load_cap = !status.mc_over_cap;
            end
            S_DP0:
            begin
                cmd.tbl_rd = TRD_SELF;
            end
            S_DP1:
            begin
                cmd.tbl_rd = TRD_C0;
            end
            S_DP2:
            begin
                cmd.tbl_rd = TRD_C1;
            end
            S_DP3:
            begin
                cmd.tbl_rd = TRD_C2;
            end
            S_DP4:
            begin
                cmd.tbl_rd = TRD_C3;
            end
            S_DPW:
            begin
                cmd.tbl_wr_acc = 1'b1;
                cmd.v_dec      = !status.v_at_mc;
            end
            S_NEXT:
            begin
                cmd.i_next = !status.main_last;
            end
            S_RES_RD:
            begin
                cmd.tbl_rd = TRD_CAP;
            end
            S_RES:
            begin
                cmd.out_load    = !status.out_busy;
                cmd.cnt_clear   = !status.out_busy;
                cmd.sweep_clear = !status.out_busy;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

### src/kwa_dp.sv
// Datapath: item and attachment memories, value table, choice sums and result register.
`timescale 1ns / 1ps

module kwa_dp import kwa_pkg::*;
#(
    parameter int MAX_ITEMS   = DEF_MAX_ITEMS,
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  cmd_t                   cmd,
    output status_t                status,
    input  logic                   cfg_wr_en,
    input  logic [BUDGET_W-1:0]    cfg_wr_data,
    input  logic                   s_axis_tvalid,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    input  logic                   s_axis_tlast,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    localparam int AW    = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CW    = $clog2(MAX_ITEMS + 1);
    localparam int TW    = $clog2(TABLE_DEPTH);
    localparam int XW    = (TW > COMBO_COST_W) ? TW : COMBO_COST_W;
    localparam int ATT_W = 2 * AW + ACNT_W;

    // Input fields
    logic [COST_W-1:0]   in_cost;
    logic [PRIO_W-1:0]   in_prio;
    logic [PARENT_W-1:0] in_parent;

    assign in_cost   = s_axis_tdata[COST_W-1:0];
    assign in_prio   = s_axis_tdata[COST_W+PRIO_W-1:COST_W];
    assign in_parent = s_axis_tdata[COST_W+PRIO_W+PARENT_W-1:COST_W+PRIO_W];

    logic                accept;
    logic                store_ok;
    logic                parent_ok;
    logic [AW-1:0]       par_addr;

    logic [BUDGET_W-1:0] budget_reg;
    logic [TW-1:0]       cap;
    logic [CW-1:0]       item_cnt_reg;
    logic [AW-1:0]       sweep_reg;
    logic [AW-1:0]       i_reg;
    logic [TW-1:0]       v_reg;

    // Memories
    item_word_t          item_mem [MAX_ITEMS];
    logic [ATT_W-1:0]    att_mem  [MAX_ITEMS];
    logic [VALUE_W-1:0]  tbl_mem  [TABLE_DEPTH];

    item_word_t          item_rdata;
    item_word_t          item_wdata;
    logic [AW-1:0]       item_raddr;
    logic                item_re;
    logic [ATT_W-1:0]    att_rdata;
    logic [AW-1:0]       att_raddr;
    logic                att_re;
    logic [AW-1:0]       att_waddr;
    logic [ATT_W-1:0]    att_wdata;
    logic                att_we;
    logic [VALUE_W-1:0]  tbl_rdata;
    logic [TW-1:0]       tbl_raddr;
    logic                tbl_re;
    logic                tbl_we;
    logic [VALUE_W-1:0]  tbl_wdata;

    // Attachment update stage
    logic                stage_valid_reg;
    logic [AW-1:0]       stage_addr_reg;
    logic [AW-1:0]       stage_idx_reg;
    logic                lastwr_valid_reg;
    logic [AW-1:0]       lastwr_addr_reg;
    logic [ATT_W-1:0]    lastwr_data_reg;
    logic [ATT_W-1:0]    att_eff;
    logic [ATT_W-1:0]    att_upd;

    // Main item and its attachments
    logic [COST_W-1:0]   mc_reg;
    logic [VALUE_W-1:0]  mv_reg;
    logic [COST_W-1:0]   ac_reg;
    logic [VALUE_W-1:0]  av_reg;
    logic [COST_W-1:0]   bc_reg;
    logic [VALUE_W-1:0]  bv_reg;
    logic [ACNT_W-1:0]   n_reg;
    logic [AW-1:0]       second_reg;
    logic [VALUE_W-1:0]  item_prod;

    logic [COMBO_COST_W-1:0] combo_cost_reg [4];
    logic [COMBO_VAL_W-1:0]  combo_val_reg  [4];
    logic [3:0]              combo_en_reg;

    // Relaxation
    tbl_rd_t             tag_reg;
    logic [1:0]          fold_sel;
    logic                fold_on;
    logic                self_load;
    logic                fits;
    logic [CAND_W-1:0]   cand;
    logic [VALUE_W-1:0]  acc_reg;
    logic [VALUE_W-1:0]  acc_next;
    logic [1:0]          rd_sel;

    logic                out_valid_reg;
    logic [VALUE_W-1:0]  out_data_reg;

    // Choice index carried by a table read kind
    function automatic logic [1:0] choice_of(input tbl_rd_t kind);
        logic [1:0] k;
        k = 2'd0;
        unique case (kind)
            TRD_C1:  k = 2'd1;
            TRD_C2:  k = 2'd2;
            TRD_C3:  k = 2'd3;
            default: k = 2'd0;
        endcase
        return k;
    endfunction

    // Acceptance and item numbering
    assign accept    = s_axis_tvalid && cmd.in_ready;
    assign store_ok  = (int'(item_cnt_reg) < MAX_ITEMS);
    assign parent_ok = (in_parent != '0) && (int'(in_parent) <= MAX_ITEMS);
    assign par_addr  = AW'(int'(in_parent) - 1);

    // Budget register and clamped capacity
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            budget_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            budget_reg <= cfg_wr_data;
        end
    end

    always_comb
    begin
        if (int'(budget_reg) > TABLE_DEPTH - 1)
        begin
            cap = TW'(TABLE_DEPTH - 1);
        end
        else
        begin
            cap = TW'(budget_reg);
        end
    end

    // Counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_cnt_reg <= '0;
            sweep_reg    <= '0;
            i_reg        <= '0;
            v_reg        <= '0;
        end
        else
        begin
            if (cmd.cnt_clear)
            begin
                item_cnt_reg <= '0;
            end
            else if (accept && store_ok)
            begin
                item_cnt_reg <= item_cnt_reg + CW'(1);
            end

            if (cmd.sweep_clear)
            begin
                sweep_reg <= '0;
            end
            else if (cmd.att_clr)
            begin
                sweep_reg <= sweep_reg + AW'(1);
            end

            if (cmd.i_first)
            begin
                i_reg <= '0;
            end
            else if (cmd.i_next)
            begin
                i_reg <= i_reg + AW'(1);
            end

            if (cmd.v_load_cap)
            begin
                v_reg <= cap;
            end
            else if (cmd.v_dec)
            begin
                v_reg <= v_reg - TW'(1);
            end
        end
    end

    // Item memory: written on load, read by the walk
    assign item_wdata.is_main = (in_parent == '0);
    assign item_wdata.prio    = in_prio;
    assign item_wdata.cost    = in_cost;
    assign item_re            = (cmd.item_rd != IRD_NONE);

    always_comb
    begin
        unique case (cmd.item_rd)
            IRD_NONE: item_raddr = i_reg;
            IRD_MAIN: item_raddr = i_reg;
            IRD_A:    item_raddr = att_rdata[ACNT_W+AW-1:ACNT_W];
            IRD_B:    item_raddr = second_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (accept && store_ok)
        begin
            item_mem[AW'(item_cnt_reg)] <= item_wdata;
        end
        if (item_re)
        begin
            item_rdata <= item_mem[item_raddr];
        end
    end

    // Attachment memory: read-modify-write on load, with a one-deep bypass
    assign att_re    = (accept && store_ok && parent_ok) || cmd.att_rd_main;
    assign att_raddr = cmd.att_rd_main ? i_reg : par_addr;
    assign att_eff   = (lastwr_valid_reg && (lastwr_addr_reg == stage_addr_reg))
                       ? lastwr_data_reg : att_rdata;

    always_comb
    begin
        att_upd = att_eff;
        unique case (att_eff[ACNT_W-1:0])
            2'd0:
            begin
                att_upd[ACNT_W+AW-1:ACNT_W] = stage_idx_reg;
                att_upd[ACNT_W-1:0]         = 2'd1;
            end
            2'd1:
            begin
                att_upd[ACNT_W+2*AW-1:ACNT_W+AW] = stage_idx_reg;
                att_upd[ACNT_W-1:0]              = 2'd2;
            end
            default:
            begin
                att_upd = att_eff;
            end
        endcase
    end

    assign att_we    = cmd.att_clr || stage_valid_reg;
    assign att_waddr = cmd.att_clr ? sweep_reg : stage_addr_reg;
    assign att_wdata = cmd.att_clr ? '0 : att_upd;

    always_ff @(posedge clk)
    begin
        if (att_we)
        begin
            att_mem[att_waddr] <= att_wdata;
        end
        if (att_re)
        begin
            att_rdata <= att_mem[att_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg  <= 1'b0;
            lastwr_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg  <= accept && store_ok && parent_ok;
            lastwr_valid_reg <= stage_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        stage_addr_reg  <= par_addr;
        stage_idx_reg   <= AW'(item_cnt_reg);
        lastwr_addr_reg <= stage_addr_reg;
        lastwr_data_reg <= att_upd;
    end

    // Main item, attachments and the four choices
    assign item_prod = VALUE_W'(item_rdata.cost) * VALUE_W'(item_rdata.prio);

    always_ff @(posedge clk)
    begin
        if (cmd.cap_main)
        begin
            mc_reg     <= item_rdata.cost;
            mv_reg     <= item_prod;
            n_reg      <= att_rdata[ACNT_W-1:0];
            second_reg <= att_rdata[ACNT_W+2*AW-1:ACNT_W+AW];
        end
        if (cmd.cap_a)
        begin
            ac_reg <= (n_reg != 2'd0) ? item_rdata.cost : '0;
            av_reg <= (n_reg != 2'd0) ? item_prod : '0;
        end
        if (cmd.cap_b)
        begin
            bc_reg <= (n_reg > 2'd1) ? item_rdata.cost : '0;
            bv_reg <= (n_reg > 2'd1) ? item_prod : '0;
        end
        if (cmd.cap_combo)
        begin
            combo_cost_reg[0] <= COMBO_COST_W'(mc_reg);
            combo_cost_reg[1] <= COMBO_COST_W'(mc_reg) + COMBO_COST_W'(ac_reg);
            combo_cost_reg[2] <= COMBO_COST_W'(mc_reg) + COMBO_COST_W'(bc_reg);
            combo_cost_reg[3] <= COMBO_COST_W'(mc_reg) + COMBO_COST_W'(ac_reg)
                                 + COMBO_COST_W'(bc_reg);
            combo_val_reg[0]  <= COMBO_VAL_W'(mv_reg);
            combo_val_reg[1]  <= COMBO_VAL_W'(mv_reg) + COMBO_VAL_W'(av_reg);
            combo_val_reg[2]  <= COMBO_VAL_W'(mv_reg) + COMBO_VAL_W'(bv_reg);
            combo_val_reg[3]  <= COMBO_VAL_W'(mv_reg) + COMBO_VAL_W'(av_reg)
                                 + COMBO_VAL_W'(bv_reg);
            combo_en_reg      <= {n_reg > 2'd1, n_reg > 2'd1, n_reg != 2'd0, 1'b1};
        end
    end

    // Value table read address
    assign rd_sel = choice_of(cmd.tbl_rd);
    assign tbl_re = (cmd.tbl_rd != TRD_NONE);

    always_comb
    begin
        unique case (cmd.tbl_rd)
            TRD_C0, TRD_C1, TRD_C2, TRD_C3:
                tbl_raddr = TW'(XW'(v_reg) - XW'(combo_cost_reg[rd_sel]));
            TRD_CAP:
                tbl_raddr = cap;
            default:
                tbl_raddr = v_reg;
        endcase
    end

    // Fold the data of the previous read into the running best
    always_comb
    begin
        fold_on   = 1'b0;
        self_load = 1'b0;
        unique case (tag_reg)
            TRD_SELF:                       self_load = 1'b1;
            TRD_C0, TRD_C1, TRD_C2, TRD_C3: fold_on   = 1'b1;
            default:                        fold_on   = 1'b0;
        endcase
    end

    assign fold_sel = choice_of(tag_reg);
    assign fits     = combo_en_reg[fold_sel]
                      && (XW'(v_reg) >= XW'(combo_cost_reg[fold_sel]));
    assign cand     = CAND_W'(tbl_rdata) + CAND_W'(combo_val_reg[fold_sel]);

    always_comb
    begin
        acc_next = acc_reg;
        if (self_load)
        begin
            acc_next = tbl_rdata;
        end
        else if (fold_on && fits && (cand > CAND_W'(acc_reg)))
        begin
            acc_next = VALUE_W'(cand);
        end
    end

    assign tbl_we    = cmd.tbl_wr_zero || cmd.tbl_wr_acc;
    assign tbl_wdata = cmd.tbl_wr_zero ? '0 : acc_next;

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        if (tbl_we)
        begin
            tbl_mem[v_reg] <= tbl_wdata;
        end
        if (tbl_re)
        begin
            tbl_rdata <= tbl_mem[tbl_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg <= TRD_NONE;
        end
        else
        begin
            tag_reg <= cmd.tbl_rd;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_data_reg <= tbl_rdata;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_TDATA_W'(out_data_reg);

    // Status
    assign status.last_accepted = accept && s_axis_tlast;
    assign status.sweep_last    = (sweep_reg == AW'(MAX_ITEMS - 1));
    assign status.no_items      = (item_cnt_reg == '0);
    assign status.main_last     = ((CW'(i_reg) + CW'(1)) == item_cnt_reg);
    assign status.is_main       = item_rdata.is_main;
    assign status.mc_over_cap   = (XW'(mc_reg) > XW'(cap));
    assign status.v_zero        = (v_reg == '0);
    assign status.v_at_mc       = (XW'(v_reg) == XW'(mc_reg));
    assign status.out_busy      = out_valid_reg;

endmodule

### tb/knapsack_with_attachments_tb.sv
// Self-checking testbench for the main-plus-attachments knapsack solver.
`timescale 1ns / 1ps

module knapsack_with_attachments_tb;
    import kwa_pkg::*;

    localparam int QUIET_LIMIT   = 200000;   // cycles with no transaction before giving up
    localparam int SETTLE_CYCLES = 100;      // covers the attachment clearing pass
    localparam int FULL_BUDGET   = 32767;
    localparam int ITEMS_PER_MODE = 550;

    // Predicts the best value of each problem and checks the results against it
    class best_value_board;
        int                 budget;
        int                 cost_mem [DEF_MAX_ITEMS + 1];
        int                 prio_mem [DEF_MAX_ITEMS + 1];
        int                 parent_mem [DEF_MAX_ITEMS + 1];
        int                 first_att [DEF_MAX_ITEMS + 1];
        int                 second_att [DEF_MAX_ITEMS + 1];
        int                 att_cnt [DEF_MAX_ITEMS + 1];
        int                 item_count;
        int                 best_at [DEF_TABLE_DEPTH];
        logic [VALUE_W-1:0] values_due [$];
        int                 errors;

        function new();
            budget     = 0;
            item_count = 0;
            errors     = 0;
            foreach (att_cnt[j])
            begin
                att_cnt[j] = 0;
            end
        endfunction

        function void set_budget(logic [BUDGET_W-1:0] value);
            budget = value;
        endfunction

        function int pending();
            return values_due.size();
        endfunction

        // One 0/1 relaxation of table entry v by a choice of cost c and value val
        function void relax(int v, int c, int val);
            int cand;
            if (v >= c)
            begin
                cand = best_at[v - c] + val;
                if (cand > best_at[v])
                    best_at[v] = cand;
            end
        endfunction

        // Grouped knapsack over capacities from the cap down to each main item's cost
        function logic [VALUE_W-1:0] best_at_budget();
            int cap;
            int mc;
            int mv;
            int ac;
            int av;
            int bc;
            int bv;
            int n;
            cap = budget;
            if (cap > DEF_TABLE_DEPTH - 1)
                cap = DEF_TABLE_DEPTH - 1;
            for (int v = 0; v <= cap; v++)
                best_at[v] = 0;
            for (int i = 1; i <= item_count; i++)
            begin
                if (parent_mem[i] != 0)
                    continue;
                mc = cost_mem[i];
                mv = mc * prio_mem[i];
                n  = att_cnt[i];
                ac = 0;
                av = 0;
                bc = 0;
                bv = 0;
                if (n > 0 && first_att[i] <= DEF_MAX_ITEMS)
                begin
                    ac = cost_mem[first_att[i]];
                    av = ac * prio_mem[first_att[i]];
                end
                if (n > 1 && second_att[i] <= DEF_MAX_ITEMS)
                begin
                    bc = cost_mem[second_att[i]];
                    bv = bc * prio_mem[second_att[i]];
                end
                if (mc > cap)
                    continue;
                for (int v = cap; v >= mc; v--)
                begin
                    relax(v, mc, mv);
                    if (n > 0)
                        relax(v, mc + ac, mv + av);
                    if (n > 1)
                    begin
                        relax(v, mc + bc, mv + bv);
                        relax(v, mc + ac + bc, mv + av + bv);
                    end
                end
            end
            return VALUE_W'(best_at[cap]);
        endfunction

        // Accepted input transaction: store the item, solve on the last one
        function void take_item(logic [COST_W-1:0] cost, logic [PRIO_W-1:0] prio,
                                logic [PARENT_W-1:0] parent, logic last);
            int idx;
            int n;
            if (item_count < DEF_MAX_ITEMS)
            begin
                idx             = item_count + 1;
                item_count      = idx;
                cost_mem[idx]   = cost;
                prio_mem[idx]   = prio;
                parent_mem[idx] = parent;
                if (parent != 0 && parent <= DEF_MAX_ITEMS)
                begin
                    n = att_cnt[parent];
                    if (n == 0)
                        first_att[parent] = idx;
                    else if (n == 1)
                        second_att[parent] = idx;
                    if (n < 2)
                        att_cnt[parent] = n + 1;
                end
            end
            if (last)
            begin
                values_due.push_back(best_at_budget());
                foreach (att_cnt[j])
                begin
                    att_cnt[j] = 0;
                end
                item_count = 0;
            end
        endfunction

        task report(string msg);
            errors++;
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        endtask

        // Accepted output transaction against the oldest prediction
        task check_best_value(logic [VALUE_W-1:0] got);
            logic [VALUE_W-1:0] want;
            if (values_due.size() == 0)
            begin
                report($sformatf("best_value %0d arrived with no problem pending", got));
            end
            else
            begin
                want = values_due.pop_front();
                if (got !== want)
                    report($sformatf("best_value %0d, predicted %0d", got, want));
            end
        endtask
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [BUDGET_W-1:0]    cfg_wr_data = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   s_axis_tlast = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    best_value_board board;
    int              tx_idle_pct = 0;
    int              rx_idle_pct = 0;
    int              items_sent = 0;
    int              quiet_cycles = 0;

    knapsack_with_attachments u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Result side: check each transaction, then pick next cycle's ready
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
                board.check_best_value(m_axis_tdata[VALUE_W-1:0]);
            m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("** knapsack_with_attachments: FAILED **");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // One item transaction, with random idle cycles in front
    task automatic send_item(input logic [COST_W-1:0] cost, input logic [PRIO_W-1:0] prio,
                             input logic [PARENT_W-1:0] parent, input logic last);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_TDATA_W - COST_W - PRIO_W - PARENT_W){1'b0}}, parent, prio, cost};
        s_axis_tlast  <= last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        board.take_item(cost, prio, parent, last);
        items_sent++;
    endtask

    // Wait until the block is idle, then write the budget
    task automatic program_budget(input int value);
        s_axis_tvalid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= BUDGET_W'(value);
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        board.set_budget(BUDGET_W'(value));
    endtask

    // One random problem: mostly mains and attachments of real mains, some noise
    task automatic send_problem(input int n_items, input int cost_hi, input bit near_cap);
        int                  mains [$];
        int                  pick;
        logic [COST_W-1:0]   cost;
        logic [PRIO_W-1:0]   prio;
        logic [PARENT_W-1:0] parent;
        for (int k = 1; k <= n_items; k++)
        begin
            pick = $urandom_range(99);
            if (k == 1 || pick < 45)
                parent = '0;
            else if (pick < 85)
                parent = PARENT_W'(mains[$urandom_range(mains.size() - 1)]);
            else
                parent = PARENT_W'($urandom_range(127));
            if (parent == 0 && k <= DEF_MAX_ITEMS)
                mains.push_back(k);
            if (near_cap && parent == 0)
                cost = COST_W'($urandom_range(FULL_BUDGET, 32000));
            else if (!near_cap && $urandom_range(15) == 0)
                cost = COST_W'($urandom);
            else
                cost = COST_W'($urandom_range(cost_hi));
            prio = PRIO_W'($urandom);
            send_item(cost, prio, parent, k == n_items);
        end
    endtask

    // Random budget phases until the item count for this idle mode is reached
    task automatic run_random_mode(input int n_target);
        int start_count;
        int r;
        int budget;
        int n_prob;
        int n;
        start_count = items_sent;
        while (items_sent - start_count < n_target)
        begin
            r = $urandom_range(99);
            if (r < 3)
            begin
                budget = FULL_BUDGET;
                n_prob = 1;
            end
            else if (r < 11)
            begin
                budget = $urandom_range(1023, 64);
                n_prob = $urandom_range(3, 1);
            end
            else
            begin
                budget = (r < 16) ? 0 : (r < 21) ? 63 : $urandom_range(63);
                n_prob = $urandom_range(6, 1);
            end
            program_budget(budget);
            for (int p = 0; p < n_prob; p++)
            begin
                if (r < 3)
                begin
                    send_problem($urandom_range(3, 1), 1000, 1'b1);
                end
                else if (r < 11)
                begin
                    send_problem($urandom_range(3, 1), budget, 1'b0);
                end
                else
                begin
                    n = ($urandom_range(19) == 0) ? $urandom_range(72, 65) : $urandom_range(12, 1);
                    send_problem(n, budget + 2, 1'b0);
                end
            end
        end
    endtask

    initial
    begin
        board = new();
        tx_idle_pct = 14;
        rx_idle_pct = 58;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Budget at its reset value of zero
        send_item(15'd3, 3'd5, 7'd0, 1'b0);
        send_item(15'd0, 3'd7, 7'd0, 1'b1);

        // Attachments: two kept, third ignored, bad, nested, forward and absent parents
        program_budget(20);
        send_item(15'd5, 3'd3, 7'd0, 1'b0);
        send_item(15'd4, 3'd7, 7'd1, 1'b0);
        send_item(15'd6, 3'd5, 7'd1, 1'b0);
        send_item(15'd1, 3'd7, 7'd1, 1'b0);
        send_item(15'd10, 3'd2, 7'd0, 1'b0);
        send_item(15'd2, 3'd7, 7'd127, 1'b0);
        send_item(15'd1, 3'd7, 7'd2, 1'b0);
        send_item(15'd3, 3'd4, 7'd9, 1'b0);
        send_item(15'd7, 3'd1, 7'd0, 1'b0);
        send_item(15'd2, 3'd7, 7'd64, 1'b0);
        send_item(15'd0, 3'd0, 7'd0, 1'b1);

        // Full budget with the largest costs and values
        program_budget(FULL_BUDGET);
        send_item(15'd32767, 3'd7, 7'd0, 1'b0);
        send_item(15'd32000, 3'd7, 7'd0, 1'b0);
        send_item(15'd700, 3'd7, 7'd2, 1'b1);

        // Single-item problems
        program_budget(15);
        send_item(15'd15, 3'd7, 7'd0, 1'b1);
        program_budget(0);
        send_item(15'd0, 3'd7, 7'd0, 1'b1);

        run_random_mode(ITEMS_PER_MODE);
        tx_idle_pct = 58;
        rx_idle_pct = 14;
        run_random_mode(ITEMS_PER_MODE);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        run_random_mode(ITEMS_PER_MODE);

        // Drain the remaining results
        s_axis_tvalid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (board.errors == 0 && board.pending() == 0)
            $display("** knapsack_with_attachments: PASSED **");
        else
            $display("** knapsack_with_attachments: FAILED **");
        $finish;
    end

endmodule
